FILE: hw/rtl/fis_pkg.sv
// ----------------------------------------------------------------------------
// fis_pkg
// Shared types and fixed widths for the frequency invariance scale block.
// ----------------------------------------------------------------------------
`default_nettype none

package fis_pkg;

   localparam int CNT_W   = 64;
   localparam int RATIO_W = 32;
   localparam int SCALE_W = 11;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 32'd1048576;

   typedef struct packed {
      logic [CNT_W-1:0] core_cycles;
      logic [CNT_W-1:0] active_time;
   } req_payload_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale_factor;
   } rsp_payload_type;

   typedef logic [RATIO_W-1:0] csr_payload_type;

   typedef struct packed {
      logic               start;
      logic [CNT_W-1:0]   dcore;
      logic [CNT_W-1:0]   dact;
      logic [RATIO_W-1:0] ratio;
   } fis_cmd_type;

   typedef struct packed {
      logic               busy;
      logic [SCALE_W-1:0] result;
   } fis_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/fis_chan_if.sv
// ----------------------------------------------------------------------------
// fis_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fis_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/fis_muldiv.sv
// ----------------------------------------------------------------------------
// fis_muldiv
// Bit-serial multiply (64 x 32, low 64 bits kept), shift, restoring divide
// one quotient bit per cycle, then saturation at the capacity scale.
// ----------------------------------------------------------------------------
`default_nettype none

module fis_muldiv
   import fis_pkg::*;
#(
   parameter int CAP_SHIFT = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fis_cmd_type cmd,
   output fis_stat_type     stat
);

   localparam int DW    = CNT_W - CAP_SHIFT;
   localparam int STEPW = $clog2(DW);
   localparam logic [STEPW-1:0] MUL_LAST = STEPW'(RATIO_W - 1);
   localparam logic [STEPW-1:0] DIV_LAST = STEPW'(DW - 1);
   localparam logic [DW-1:0]    LIMIT    = {{(DW-1){1'b0}}, 1'b1} << CAP_SHIFT;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SAT
   } state_type;

   state_type          state_ff, state_in;
   logic [STEPW-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   mcand_ff, mcand_in;
   logic [RATIO_W-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0]   dact_ff, dact_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [DW-1:0]      quo_ff, quo_in;
   logic [SCALE_W-1:0] result_ff, result_in;

   logic [CNT_W-1:0]   acc_sum;
   logic [CNT_W:0]     rem_sh;
   logic [CNT_W:0]     rem_sub;
   logic               q_bit;

   always_comb begin
      acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      q_bit   = rem_sh >= {1'b0, dact_ff};
      rem_sub = rem_sh - {1'b0, dact_ff};
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dact_in   = dact_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      result_in = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               acc_in    = '0;
               mcand_in  = cmd.dcore;
               mplier_in = cmd.ratio;
               dact_in   = cmd.dact;
               step_in   = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[CNT_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[RATIO_W-1:1]};
            step_in   = step_ff + 1'b1;
            if (step_ff == MUL_LAST) begin
               quo_in   = DW'(acc_sum >> CAP_SHIFT);
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            quo_in  = {quo_ff[DW-2:0], q_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            result_in = (quo_ff > LIMIT) ? LIMIT[SCALE_W-1:0] : quo_ff[SCALE_W-1:0];
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dact_ff   <= dact_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign stat.busy   = state_ff != ST_IDLE;
   assign stat.result = result_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/frequency_invariance_scale.sv
// ----------------------------------------------------------------------------
// frequency_invariance_scale
// Per-tick frequency scale from core-cycle and active-time counter deltas.
//
//   channel  dir  beat
//   req_bus  in   core_cycles[63:0], active_time[63:0]
//   rsp_bus  out  scale_factor[10:0]
//   csr_bus  in   max_ratio_scale[31:0]
//
// A tick with both counters increasing has its result computed by the bit-serial
// multiply and divide after accept; the next tick is taken once that result has
// moved into the output register.
// A tick without a result is done in its accept cycle.
// Reset is synchronous; it clears the previous samples and reloads the ratio.
// A held result does not block the next tick; only a second finished
// result waits for the output register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_invariance_scale
   import fis_pkg::*;
#(
   parameter int CAP_SHIFT = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fis_chan_if.sink   req_bus,
   fis_chan_if.source rsp_bus,
   fis_chan_if.sink   csr_bus
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   prev_core_ff, prev_core_in;
   logic [CNT_W-1:0]   prev_act_ff, prev_act_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCALE_W-1:0] rsp_scale_ff, rsp_scale_in;

   fis_cmd_type  cmd;
   fis_stat_type stat;
   logic         req_take;
   logic         slot_free;
   logic         core_up;
   logic         act_up;

   fis_muldiv #(
      .CAP_SHIFT (CAP_SHIFT)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_bus.ready = state_ff == ST_IDLE;
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign core_up       = req_bus.data.core_cycles > prev_core_ff;
   assign act_up        = req_bus.data.active_time > prev_act_ff;

   assign cmd.start = req_take && core_up && act_up;
   assign cmd.dcore = req_bus.data.core_cycles - prev_core_ff;
   assign cmd.dact  = req_bus.data.active_time - prev_act_ff;
   assign cmd.ratio = ratio_ff;

   always_comb begin
      state_in     = state_ff;
      prev_core_in = prev_core_ff;
      prev_act_in  = prev_act_ff;
      ratio_in     = ratio_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_scale_in = rsp_scale_ff;
      if (csr_bus.valid) begin
         ratio_in = csr_bus.data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               prev_core_in = req_bus.data.core_cycles;
               prev_act_in  = req_bus.data.active_time;
               if (cmd.start) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!stat.busy && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_scale_in = stat.result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_core_ff <= '0;
         prev_act_ff  <= '0;
         ratio_ff     <= RATIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_core_ff <= prev_core_in;
         prev_act_ff  <= prev_act_in;
         ratio_ff     <= ratio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_scale_ff <= rsp_scale_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.data.scale_factor = rsp_scale_ff;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the frequency invariance scale block against its own predictor.
// Counter samples are sent as bursts with random gaps. Results are drained
// under a stall pattern and compared in order against predicted scales.
// The ratio register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module testbench
   import fis_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP_SHIFT      = 10;
   localparam int SETTLE         = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_TICKS    = 155;

   class scale_predictor;
      logic [CNT_W-1:0]   last_core;
      logic [CNT_W-1:0]   last_act;
      logic [RATIO_W-1:0] ratio;
      logic [SCALE_W-1:0] expected_scales[$];
      int unsigned        mismatches;
      int unsigned        ticks;
      int unsigned        checked;

      function new();
         last_core  = '0;
         last_act   = '0;
         ratio      = RATIO_RESET;
         mismatches = 0;
         ticks      = 0;
         checked    = 0;
      endfunction

      function void note_ratio(csr_payload_type value);
         ratio = value;
      endfunction

      function void note_tick(req_payload_type beat);
         logic [CNT_W-1:0] dcore;
         logic [CNT_W-1:0] dact;
         logic [CNT_W-1:0] product;
         logic [CNT_W-1:0] quot;
         logic [CNT_W-1:0] cap;
         bit               rising;
         rising  = (beat.core_cycles > last_core) && (beat.active_time > last_act);
         dcore   = beat.core_cycles - last_core;
         dact    = beat.active_time - last_act;
         last_core = beat.core_cycles;
         last_act  = beat.active_time;
         ticks++;
         if (rising) begin
            cap     = 64'd1 << CAP_SHIFT;
            product = dcore * {32'd0, ratio};
            quot    = (product >> CAP_SHIFT) / dact;
            if (quot > cap) begin
               quot = cap;
            end
            expected_scales.push_back(quot[SCALE_W-1:0]);
         end
      endfunction

      task report_mismatch(string msg);
         $display("ERROR %0t ns: %s", $time, msg);
         mismatches++;
      endtask

      task check_scale(rsp_payload_type beat);
         logic [SCALE_W-1:0] want;
         if (expected_scales.size() == 0) begin
            report_mismatch($sformatf("unexpected scale_factor %0d", beat.scale_factor));
         end else begin
            want = expected_scales.pop_front();
            checked++;
            if (beat.scale_factor !== want) begin
               report_mismatch($sformatf("scale_factor %0d, expected %0d",
                                         beat.scale_factor, want));
            end
         end
      endtask

      task check_drained();
         if (expected_scales.size() != 0) begin
            report_mismatch($sformatf("%0d scale results never arrived",
                                      expected_scales.size()));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   fis_chan_if #(.payload_type(req_payload_type)) req_if ();
   fis_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   fis_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   frequency_invariance_scale #(
      .CAP_SHIFT (CAP_SHIFT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   scale_predictor sb = new();

   int unsigned burst_left = 0;
   int unsigned ratio_writes = 0;
   int unsigned quiet = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // beat monitors and watchdog
   always @(posedge clock) begin
      if (!reset && csr_if.valid && csr_if.ready) begin
         sb.note_ratio(csr_if.data);
      end
      if (!reset && req_if.valid && req_if.ready) begin
         sb.note_tick(req_if.data);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_scale(rsp_if.data);
      end
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // result stall pattern
   initial begin
      int mode;
      int left;
      rsp_if.ready <= 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(64, 256);
         end
         left--;
         case (mode)
            0: begin
               rsp_if.ready <= 1'b1;
            end
            1: begin
               rsp_if.ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_if.ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   task automatic send_tick(input logic [CNT_W-1:0] core, input logic [CNT_W-1:0] act);
      int unsigned gap;
      req_payload_type beat;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) == 0) begin
            gap = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            gap = $urandom_range(13, 120);
         end else begin
            gap = $urandom_range(1, 12);
         end
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      beat.core_cycles = core;
      beat.active_time = act;
      req_if.valid <= 1'b1;
      req_if.data  <= beat;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.expected_scales.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_ratio(input csr_payload_type value);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      ratio_writes++;
   endtask

   initial begin
      logic [CNT_W-1:0] core;
      logic [CNT_W-1:0] act;
      logic [CNT_W-1:0] dcore;
      logic [CNT_W-1:0] dact;
      csr_payload_type  plan[6];
      int               kind;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset ratio, first tick from zero, stalls, wraps, extremes
      send_tick(64'd0, 64'd0);
      send_tick(64'd1, 64'd1);
      send_tick(64'd1001, 64'd2001);
      send_tick(64'd1001, 64'd3001);
      send_tick(64'd2001, 64'd3001);
      send_tick(64'd3001, 64'd5001);
      send_tick(64'd2001, 64'd6001);
      send_tick(64'd4001, 64'd7001);
      send_tick(64'd5001, 64'd7000);
      send_tick(64'd5002, '1);
      send_tick('1, 64'd0);
      send_tick(64'd0, 64'd5);
      send_tick('1, '1);
      send_tick(64'd0, 64'd0);
      send_tick(64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);
      core = 64'hAAAA_AAAA_AAAA_AAAA;
      act  = 64'h5555_5555_5555_5555;
      send_tick(core, act);

      // full-scale ratio, product wraps
      set_ratio('1);
      core += 64'h0000_0100_0000_0000;
      act  += 64'd3;
      send_tick(core, act);
      core += 64'd7;
      act  += 64'h0000_0000_FFFF_FFFF;
      send_tick(core, act);

      set_ratio('0);
      core += 64'd1000;
      act  += 64'd1;
      send_tick(core, act);
      core += 64'h0FFF_FFFF_FFFF_FFFF;
      act  += 64'd9;
      send_tick(core, act);

      set_ratio(32'd1);
      core += 64'h0000_0000_4000_0000;
      act  += 64'd3;
      send_tick(core, act);
      core += 64'h0000_0000_0010_0000;
      act  += 64'd700;
      send_tick(core, act);

      plan[0] = RATIO_RESET;
      plan[1] = $urandom_range(32'h0001_0000, 32'h0040_0000);
      plan[2] = '1;
      plan[3] = $urandom();
      plan[4] = '0;
      plan[5] = $urandom_range(32'h0008_0000, 32'h0020_0000);

      for (int p = 0; p < 6; p++) begin
         set_ratio(plan[p]);
         repeat (PHASE_TICKS) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
               dact = (rand64() >> $urandom_range(8, 63)) + 64'd1;
               if ($urandom_range(0, 1) == 1) begin
                  dcore = (dact >> 10) * 64'($urandom_range(0, 1300)) +
                          64'($urandom_range(1, 1024));
               end else begin
                  dcore = (rand64() >> $urandom_range(8, 63)) + 64'd1;
               end
               core += dcore;
               act  += dact;
            end else if (kind < 90) begin
               case ($urandom_range(0, 3))
                  0: begin
                     act += 64'($urandom_range(1, 5000));
                  end
                  1: begin
                     core += 64'($urandom_range(1, 5000));
                  end
                  2: begin
                     core -= 64'($urandom_range(1, 5000));
                     act  += 64'($urandom_range(1, 5000));
                  end
                  default: begin
                     core += 64'($urandom_range(1, 5000));
                     act  -= 64'($urandom_range(1, 5000));
                  end
               endcase
            end else begin
               core = rand64();
               act  = rand64();
            end
            send_tick(core, act);
         end
      end

      wait_idle();
      sb.check_drained();
      $display("Run covered %0d counter ticks and %0d scale results across %0d ratio writes.",
               sb.ticks, sb.checked, ratio_writes);
      $display("Mismatches seen: %0d", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fis_pkg.sv
hw/rtl/fis_chan_if.sv
hw/rtl/fis_muldiv.sv
hw/rtl/frequency_invariance_scale.sv
tb/testbench.sv
